@@ rtl/core/stpc_pkg.sv @@
// ----------------------------------------------------------------------------
// stpc_pkg
// Shared types, codes and fixed-point helpers for the two-point calibration
// block.
// ----------------------------------------------------------------------------
package stpc_pkg;

    typedef logic signed [31:0] q_t;
    typedef logic signed [65:0] wide_t;

    // request codes
    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_ADD      = 2'd1;
    localparam logic [1:0] REQ_FINALIZE = 2'd2;
    localparam logic [1:0] REQ_CONVERT  = 2'd3;

    // sensor kinds
    localparam logic [1:0] KIND_TEMP = 2'd0;
    localparam logic [1:0] KIND_PH   = 2'd1;
    localparam logic [1:0] KIND_EC   = 2'd2;
    localparam logic [1:0] KIND_TDS  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_FINE = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_FEW  = 2'd2;

    // result value source
    localparam logic [1:0] VSEL_ZERO = 2'd0;
    localparam logic [1:0] VSEL_RAW  = 2'd1;
    localparam logic [1:0] VSEL_ACC  = 2'd2;

    // multiplier operand selects
    localparam logic [1:0] MUL_SLOPE_RAW  = 2'd0;
    localparam logic [1:0] MUL_COEF_DELTA = 2'd1;
    localparam logic [1:0] MUL_LIN_F      = 2'd2;
    localparam logic [1:0] MUL_SLOPE_R1   = 2'd3;

    // configuration register indexes
    localparam logic CFG_PH_COEFF = 1'b0;
    localparam logic CFG_EC_COEFF = 1'b1;

    localparam q_t PH_COEFF_RST = 32'sd197;
    localparam q_t EC_COEFF_RST = 32'sd1311;

    localparam wide_t ONE_Q      = 66'sd65536;
    localparam wide_t REF_TEMP_Q = 66'sd1638400;
    localparam wide_t HALF_LSB   = 66'sd32768;
    localparam wide_t Q_MAX      = 66'sd2147483647;
    localparam wide_t Q_MIN      = -66'sd2147483648;

    // dividend magnitude |a2-a1| * 2^16 needs 49 bits
    localparam int DIV_STEPS = 49;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       add;
        logic       rd_en;
        logic       rd_slot;
        logic       cap_p1;
        logic       div_init;
        logic       div_step;
        logic       slope_fin;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       lin_ld;
        logic       acc_lin;
        logic       ph_ld;
        logic       f_ld;
        logic       ec_ld;
        logic       off_ld;
        logic       set_res;
        logic       res_ok;
        logic [1:0] res_status;
        logic [1:0] res_vsel;
        logic       emit;
    } stpc_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic [1:0] kind;
        logic       ch_ok;
        logic       slots_full;
        logic       few_pts;
        logic       cal;
        logic       out_free;
    } stpc_stat_t;

    function automatic q_t sat32(input wide_t v);
        q_t r;
        if (v > Q_MAX)
            r = Q_MAX[31:0];
        else if (v < Q_MIN)
            r = Q_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    // round to nearest, ties up, then drop 16 fraction bits
    function automatic wide_t rnd16(input wide_t p);
        wide_t r;
        r = (p + HALF_LSB) >>> 16;
        return r;
    endfunction

endpackage

@@ rtl/core/stpc_req_if.sv @@
// ----------------------------------------------------------------------------
// stpc_req_if
// Request channel: valid/ready plus one calibration request.
// ----------------------------------------------------------------------------
interface stpc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [1:0]         sensor_kind;
    logic [2:0]         channel;
    logic signed [31:0] raw_value;
    logic signed [31:0] reference_value;
    logic signed [31:0] temperature;

    modport source (output valid, req_type, sensor_kind, channel, raw_value,
                    reference_value, temperature, input ready);
    modport sink   (input valid, req_type, sensor_kind, channel, raw_value,
                    reference_value, temperature, output ready);
endinterface

@@ rtl/core/stpc_res_if.sv @@
// ----------------------------------------------------------------------------
// stpc_res_if
// Result channel: valid/ready plus one calibration result.
// ----------------------------------------------------------------------------
interface stpc_res_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [1:0]         status;
    logic               calibrated;
    logic signed [31:0] value;

    modport source (output valid, ok, status, calibrated, value, input ready);
    modport sink   (input valid, ok, status, calibrated, value, output ready);
endinterface

@@ rtl/core/stpc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// stpc_cfg_if
// Configuration write channel: valid/ready, register index and data.
// ----------------------------------------------------------------------------
interface stpc_cfg_if;
    logic               valid;
    logic               ready;
    logic               addr;
    logic signed [31:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ rtl/core/stpc_datapath.sv @@
// ----------------------------------------------------------------------------
// stpc_datapath
// Calibration tables, point memory, shared multiplier, serial divider and
// result register.
// ----------------------------------------------------------------------------
module stpc_datapath #(
    parameter int CHANNELS   = 8,
    parameter int MAX_POINTS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stpc_pkg::stpc_cmd_t  cmd,
    output stpc_pkg::stpc_stat_t stat,
    input  logic [1:0]           req_type,
    input  logic [1:0]           sensor_kind,
    input  logic [2:0]           channel,
    input  stpc_pkg::q_t         raw_value,
    input  stpc_pkg::q_t         reference_value,
    input  stpc_pkg::q_t         temperature,
    input  stpc_pkg::q_t         ph_coeff,
    input  stpc_pkg::q_t         ec_coeff,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_ok,
    output logic [1:0]           out_status,
    output logic                 out_calibrated,
    output stpc_pkg::q_t         out_value
);
    localparam int SLOTS     = 3 * CHANNELS;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int MEM_DEPTH = SLOTS * MAX_POINTS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);

    // latched request
    logic [1:0]   req_reg;
    logic [1:0]   kind_reg;
    logic [2:0]   ch_reg;
    stpc_pkg::q_t raw_reg;
    stpc_pkg::q_t ref_reg;
    stpc_pkg::q_t temp_reg;

    // per-slot tables
    stpc_pkg::q_t     slope_mem  [SLOTS];
    stpc_pkg::q_t     offset_mem [SLOTS];
    logic             flag_reg   [SLOTS];
    logic [CNT_W-1:0] cnt_reg    [SLOTS];

    // point memory: {raw, ref}
    logic [63:0] pt_mem [MEM_DEPTH];
    logic [63:0] pt_rdata_reg;

    stpc_pkg::q_t r1_reg;
    stpc_pkg::q_t a1_reg;

    logic [33:0]  rem_reg;
    logic [48:0]  quo_reg;
    logic [32:0]  dvs_reg;
    logic         neg_reg;
    logic         eq_reg;
    stpc_pkg::q_t slope_tmp_reg;

    stpc_pkg::wide_t prod_reg;
    stpc_pkg::q_t    lin_reg;
    stpc_pkg::q_t    f_reg;
    stpc_pkg::q_t    acc_reg;

    logic       res_ok_reg;
    logic [1:0] res_status_reg;
    logic [1:0] res_vsel_reg;

    logic         out_valid_reg;
    logic         out_ok_reg;
    logic [1:0]   out_status_reg;
    logic         out_cal_reg;
    stpc_pkg::q_t out_value_reg;

    logic [1:0]        store;
    logic [31:0]       slot_full;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       addr_full;
    logic [ADDR_W-1:0] mem_addr;
    logic [CNT_W-1:0]  cnt_cur;
    logic              ch_ok;
    logic [31:0]       cap;

    stpc_pkg::wide_t delta;
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    stpc_pkg::wide_t prod_c;
    stpc_pkg::wide_t rnd_p;

    stpc_pkg::q_t    r2;
    stpc_pkg::q_t    a2;
    stpc_pkg::wide_t num_w;
    stpc_pkg::wide_t den_w;
    stpc_pkg::wide_t num_abs;
    stpc_pkg::wide_t den_abs;
    logic [33:0]     rem_sh;
    stpc_pkg::wide_t quo_s;
    stpc_pkg::q_t    ec_val;
    stpc_pkg::wide_t tds_w;

    always_comb
    begin
        store     = (kind_reg >= stpc_pkg::KIND_EC) ? stpc_pkg::KIND_EC : kind_reg;
        slot_full = 32'(store) * 32'(CHANNELS) + 32'(ch_reg);
        slot      = slot_full[SLOT_W-1:0];
        ch_ok     = 32'(ch_reg) < 32'(CHANNELS);
        cnt_cur   = cnt_reg[slot];
        cap       = (store == stpc_pkg::KIND_PH) ? 32'(MAX_POINTS) : 32'd2;
        addr_full = slot_full * 32'(MAX_POINTS)
                  + (cmd.add ? 32'(cnt_cur) : 32'(cmd.rd_slot));
        mem_addr  = addr_full[ADDR_W-1:0];
    end

    always_comb
    begin
        stat.req        = req_reg;
        stat.kind       = kind_reg;
        stat.ch_ok      = ch_ok;
        stat.slots_full = 32'(cnt_cur) >= cap;
        stat.few_pts    = cnt_cur < CNT_W'(2);
        stat.cal        = flag_reg[slot];
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            kind_reg <= sensor_kind;
            ch_reg   <= channel;
            raw_reg  <= raw_value;
            ref_reg  <= reference_value;
            temp_reg <= temperature;
        end
    end

    // flags and counts must reset; slope/offset are only read once calibrated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                flag_reg[i] <= 1'b0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                flag_reg[slot] <= 1'b0;
                cnt_reg[slot]  <= '0;
            end
            else if (cmd.add)
            begin
                cnt_reg[slot] <= cnt_cur + CNT_W'(1);
            end
            else if (cmd.off_ld)
            begin
                flag_reg[slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            slope_mem[slot]  <= '0;
            offset_mem[slot] <= '0;
        end
        else if (cmd.off_ld)
        begin
            slope_mem[slot]  <= slope_tmp_reg;
            offset_mem[slot] <= stpc_pkg::sat32(stpc_pkg::wide_t'(a1_reg) - rnd_p);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add)
            pt_mem[mem_addr] <= {raw_reg, ref_reg};
        if (cmd.rd_en)
            pt_rdata_reg <= pt_mem[mem_addr];
    end

    // shared multiplier
    always_comb
    begin
        delta = stpc_pkg::wide_t'(temp_reg) - stpc_pkg::REF_TEMP_Q;
        case (cmd.mul_sel)
            stpc_pkg::MUL_SLOPE_RAW:
            begin
                ma = {slope_mem[slot][31], slope_mem[slot]};
                mb = {raw_reg[31], raw_reg};
            end
            stpc_pkg::MUL_COEF_DELTA:
            begin
                ma = (kind_reg == stpc_pkg::KIND_PH) ? {ph_coeff[31], ph_coeff}
                                                     : {ec_coeff[31], ec_coeff};
                mb = delta[32:0];
            end
            stpc_pkg::MUL_LIN_F:
            begin
                ma = {lin_reg[31], lin_reg};
                mb = {f_reg[31], f_reg};
            end
            default:
            begin
                ma = {slope_tmp_reg[31], slope_tmp_reg};
                mb = {r1_reg[31], r1_reg};
            end
        endcase
        prod_c = ma * mb;
        rnd_p  = stpc_pkg::rnd16(prod_reg);
    end

    // divider setup and step
    always_comb
    begin
        r2      = pt_rdata_reg[63:32];
        a2      = pt_rdata_reg[31:0];
        num_w   = (stpc_pkg::wide_t'(a2) - stpc_pkg::wide_t'(a1_reg)) <<< 16;
        den_w   = stpc_pkg::wide_t'(r2) - stpc_pkg::wide_t'(r1_reg);
        num_abs = num_w[65] ? -num_w : num_w;
        den_abs = den_w[65] ? -den_w : den_w;
        rem_sh  = {rem_reg[32:0], quo_reg[48]};
        quo_s   = neg_reg ? -stpc_pkg::wide_t'(quo_reg) : stpc_pkg::wide_t'(quo_reg);
        ec_val  = stpc_pkg::sat32(rnd_p);
        tds_w   = (stpc_pkg::wide_t'(ec_val) + 66'sd1) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= prod_c;
        if (cmd.cap_p1)
        begin
            r1_reg <= pt_rdata_reg[63:32];
            a1_reg <= pt_rdata_reg[31:0];
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= num_abs[48:0];
            dvs_reg <= den_abs[32:0];
            neg_reg <= num_w[65] ^ den_w[65];
            eq_reg  <= (r2 == r1_reg);
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[47:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[47:0], 1'b0};
            end
        end
        if (cmd.slope_fin)
            slope_tmp_reg <= eq_reg ? stpc_pkg::ONE_Q[31:0] : stpc_pkg::sat32(quo_s);
        if (cmd.lin_ld)
            lin_reg <= stpc_pkg::sat32(rnd_p + stpc_pkg::wide_t'(offset_mem[slot]));
        if (cmd.f_ld)
            f_reg <= stpc_pkg::sat32(stpc_pkg::ONE_Q + rnd_p);
        if (cmd.acc_lin)
            acc_reg <= lin_reg;
        else if (cmd.ph_ld)
            acc_reg <= stpc_pkg::sat32(stpc_pkg::wide_t'(lin_reg) - rnd_p);
        else if (cmd.ec_ld)
            acc_reg <= (kind_reg == stpc_pkg::KIND_TDS) ? tds_w[31:0] : ec_val;
        if (cmd.set_res)
        begin
            res_ok_reg     <= cmd.res_ok;
            res_status_reg <= cmd.res_status;
            res_vsel_reg   <= cmd.res_vsel;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_ok_reg     <= res_ok_reg;
            out_status_reg <= res_status_reg;
            out_cal_reg    <= ch_ok && flag_reg[slot];
            case (res_vsel_reg)
                stpc_pkg::VSEL_RAW: out_value_reg <= raw_reg;
                stpc_pkg::VSEL_ACC: out_value_reg <= acc_reg;
                default:            out_value_reg <= '0;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_ok         = out_ok_reg;
    assign out_status     = out_status_reg;
    assign out_calibrated = out_cal_reg;
    assign out_value      = out_value_reg;

endmodule

@@ rtl/core/stpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// stpc_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module stpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  stpc_pkg::stpc_stat_t stat,
    output stpc_pkg::stpc_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_FRD1   = 4'd2;
    localparam logic [3:0] S_FDIV0  = 4'd3;
    localparam logic [3:0] S_FDIV   = 4'd4;
    localparam logic [3:0] S_FSLOPE = 4'd5;
    localparam logic [3:0] S_FMUL   = 4'd6;
    localparam logic [3:0] S_FOFF   = 4'd7;
    localparam logic [3:0] S_CV1    = 4'd8;
    localparam logic [3:0] S_CV2    = 4'd9;
    localparam logic [3:0] S_CV3    = 4'd10;
    localparam logic [3:0] S_CV4    = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic [stpc_pkg::DIV_CNT_W-1:0] DIV_LAST =
        stpc_pkg::DIV_CNT_W'(stpc_pkg::DIV_STEPS - 1);

    logic [3:0]                       state_reg;
    logic [3:0]                       state_next;
    logic [stpc_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [stpc_pkg::DIV_CNT_W-1:0]   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_res    = 1'b1;
                cmd.res_status = stpc_pkg::STATUS_FINE;
                cmd.res_vsel   = stpc_pkg::VSEL_ZERO;
                state_next     = S_OUT;
                if (!stat.ch_ok)
                begin
                    // unknown channel: convert passes raw through
                    cmd.res_ok = (stat.req == stpc_pkg::REQ_CONVERT);
                    if (stat.req == stpc_pkg::REQ_CONVERT)
                        cmd.res_vsel = stpc_pkg::VSEL_RAW;
                end
                else
                begin
                    case (stat.req)
                        stpc_pkg::REQ_START:
                        begin
                            cmd.clear  = 1'b1;
                            cmd.res_ok = 1'b1;
                        end
                        stpc_pkg::REQ_ADD:
                        begin
                            if (stat.slots_full)
                                cmd.res_status = stpc_pkg::STATUS_FULL;
                            else
                            begin
                                cmd.add    = 1'b1;
                                cmd.res_ok = 1'b1;
                            end
                        end
                        stpc_pkg::REQ_FINALIZE:
                        begin
                            if (stat.few_pts)
                                cmd.res_status = stpc_pkg::STATUS_FEW;
                            else
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_slot = 1'b0;
                                state_next  = S_FRD1;
                            end
                        end
                        default:
                        begin
                            cmd.res_ok = 1'b1;
                            if (!stat.cal)
                                cmd.res_vsel = stpc_pkg::VSEL_RAW;
                            else
                            begin
                                cmd.res_vsel = stpc_pkg::VSEL_ACC;
                                cmd.mul_en   = 1'b1;
                                cmd.mul_sel  = stpc_pkg::MUL_SLOPE_RAW;
                                state_next   = S_CV1;
                            end
                        end
                    endcase
                end
            end
            S_FRD1:
            begin
                cmd.cap_p1  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = 1'b1;
                state_next  = S_FDIV0;
            end
            S_FDIV0:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_FDIV;
            end
            S_FDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + stpc_pkg::DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                    state_next = S_FSLOPE;
            end
            S_FSLOPE:
            begin
                cmd.slope_fin = 1'b1;
                state_next    = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = stpc_pkg::MUL_SLOPE_R1;
                state_next  = S_FOFF;
            end
            S_FOFF:
            begin
                cmd.off_ld     = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_ok     = 1'b1;
                cmd.res_status = stpc_pkg::STATUS_FINE;
                cmd.res_vsel   = stpc_pkg::VSEL_ZERO;
                state_next     = S_OUT;
            end
            S_CV1:
            begin
                cmd.lin_ld  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = stpc_pkg::MUL_COEF_DELTA;
                state_next  = S_CV2;
            end
            S_CV2:
            begin
                case (stat.kind)
                    stpc_pkg::KIND_TEMP:
                    begin
                        cmd.acc_lin = 1'b1;
                        state_next  = S_OUT;
                    end
                    stpc_pkg::KIND_PH:
                    begin
                        cmd.ph_ld  = 1'b1;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        cmd.f_ld   = 1'b1;
                        state_next = S_CV3;
                    end
                endcase
            end
            S_CV3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = stpc_pkg::MUL_LIN_F;
                state_next  = S_CV4;
            end
            S_CV4:
            begin
                cmd.ec_ld  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_load_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DECODE)
        else $error("accepted request did not reach decode");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted into a full output register");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FDIV |-> cnt_reg <= DIV_LAST)
        else $error("divider ran past its last step");

    a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.add, cmd.off_ld}))
        else $error("two table updates in one cycle");

    a_slope_before_off: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.off_ld |-> $past(cmd.mul_en) && $past(cmd.mul_sel) == stpc_pkg::MUL_SLOPE_R1)
        else $error("offset written without its product");
`endif

endmodule

@@ rtl/core/sensor_two_point_calibration_top.sv @@
// ----------------------------------------------------------------------------
// sensor_two_point_calibration_top
// Two-point linear calibration for temperature, pH and conductivity channels.
// ----------------------------------------------------------------------------
// Usage:
//   req : one request per transfer (start, add point, finalize, convert).
//   res : exactly one result per request, in request order.
//   cfg : writes the pH (index 0) and EC (index 1) temperature coefficients;
//         always ready, write only while no request is in flight.
// A convert on a calibrated channel runs more multiply steps for EC and TDS
// than for temp and pH; finalize computes the slope with the 49-step serial
// divider.
// One request is processed at a time; the next is taken once the previous
// result is loaded into the output register.
// Reset clears all calibrated flags and point counts and restores the
// coefficient defaults. A stalled result holds in the output register; the
// next request is still taken and worked, and its result waits until the
// output register drains.
// ----------------------------------------------------------------------------
module sensor_two_point_calibration_top #(
    parameter int CHANNELS   = 8,
    parameter int MAX_POINTS = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    stpc_req_if.sink     req,
    stpc_res_if.source   res,
    stpc_cfg_if.sink     cfg
);
    stpc_pkg::q_t         ph_coeff_reg;
    stpc_pkg::q_t         ec_coeff_reg;
    stpc_pkg::stpc_cmd_t  cmd;
    stpc_pkg::stpc_stat_t stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_coeff_reg <= stpc_pkg::PH_COEFF_RST;
            ec_coeff_reg <= stpc_pkg::EC_COEFF_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                stpc_pkg::CFG_PH_COEFF: ph_coeff_reg <= cfg.data;
                stpc_pkg::CFG_EC_COEFF: ec_coeff_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    stpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stpc_datapath #(
        .CHANNELS   (CHANNELS),
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (req.req_type),
        .sensor_kind     (req.sensor_kind),
        .channel         (req.channel),
        .raw_value       (req.raw_value),
        .reference_value (req.reference_value),
        .temperature     (req.temperature),
        .ph_coeff        (ph_coeff_reg),
        .ec_coeff        (ec_coeff_reg),
        .out_valid       (res.valid),
        .out_ready       (res.ready),
        .out_ok          (res.ok),
        .out_status      (res.status),
        .out_calibrated  (res.calibrated),
        .out_value       (res.value)
    );

endmodule
